[design/kbd_pkg.sv]
// Shared types, constants and the query-folding helper function of the keyboard buffer device.
`timescale 1ns / 1ps
`default_nettype none

package kbd_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 16;
  localparam int unsigned KEY_W          = 8;
  localparam int unsigned KEY_MAP_DEPTH  = 256;
  localparam int unsigned CMD_W          = 3;
  localparam int unsigned WORD_W         = 16;

  localparam logic [WORD_W-1:0] UPPER_A    = 16'h0041;
  localparam logic [WORD_W-1:0] UPPER_Z    = 16'h005A;
  localparam logic [WORD_W-1:0] CASE_DELTA = 16'h0020;
  localparam logic [WORD_W-1:0] ASCII_LF   = 16'h000A;
  localparam logic [WORD_W-1:0] KEY_RETURN = 16'h0011;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 3'd0,
    CMD_READ    = 3'd1,
    CMD_QUERY   = 3'd2,
    CMD_SET_MSG = 3'd3,
    CMD_PRESS   = 3'd4,
    CMD_RELEASE = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  typedef struct packed {
    logic clear;
    logic pop;
    logic push;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  // Upper-case letters fold to lower case and line feed folds to return.
  function automatic logic [WORD_W-1:0] fold_query(input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] k;
    k = b;
    if (b >= UPPER_A && b <= UPPER_Z) begin
      k = b + CASE_DELTA;
    end else if (b == ASCII_LF) begin
      k = KEY_RETURN;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

[design/kbd_key_fifo.sv]
// Key word FIFO: a synchronous memory with head pointer and fill count.
`timescale 1ns / 1ps
`default_nettype none

module kbd_key_fifo #(
  parameter int unsigned FifoDepth = kbd_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire kbd_pkg::fifo_ctrl_t        ctrl_i,
  input  wire logic [kbd_pkg::KEY_W-1:0]  wr_data_i,
  output logic [kbd_pkg::KEY_W-1:0]       rd_data_o,
  output kbd_pkg::fifo_stat_t             stat_o
);
  import kbd_pkg::*;

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam logic [PtrW-1:0] LastIdx = PtrW'(FifoDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(FifoDepth);
  localparam logic [SumW-1:0] DepthSum = SumW'(FifoDepth);

  logic [KEY_W-1:0] mem [FifoDepth];
  logic [KEY_W-1:0] rd_data_q;
  logic [PtrW-1:0]  head_q, head_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [SumW-1:0]  wr_sum;
  logic [SumW-1:0]  wr_wrap;
  logic [PtrW-1:0]  wr_addr;
  logic             do_pop;
  logic             do_push;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == FullCnt);
  assign do_pop       = ctrl_i.pop && !stat_o.empty;
  assign do_push      = ctrl_i.push && !stat_o.full;

  assign wr_sum  = SumW'(head_q) + SumW'(count_q);
  assign wr_wrap = (wr_sum >= DepthSum) ? (wr_sum - DepthSum) : wr_sum;
  assign wr_addr = wr_wrap[PtrW-1:0];

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctrl_i.clear) begin
      head_d  = '0;
      count_d = '0;
    end else if (do_pop) begin
      head_d  = (head_q == LastIdx) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end else if (do_push) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_addr] <= wr_data_i;
    end
    rd_data_q <= mem[head_q];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[design/keyboard_buffer_device.sv]
// Top level of the keyboard buffer device: command decode, held-key map and result register.
`timescale 1ns / 1ps
`default_nettype none

// Each beat on the input carries one CPU command or one key event, chosen by
// the command in s_axis_tuser_i, and produces exactly one result beat. An
// item passes the idle state, which accepts it and reads the key FIFO and
// held-key memories, then the execute state, which updates them and loads the
// result register; the next beat is accepted only after that, and only while
// the output register is free. After reset the held-key memory is cleared one
// entry per cycle, which keeps the input stalled until every entry is cleared.
module keyboard_buffer_device #(
  parameter int unsigned FifoDepth = kbd_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // [15:0] register_b, [23:16] key_word
  input  wire logic [2:0]  s_axis_tuser_i,   // [2:0] command
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [15:0] c_value, [31:16] irq_message
  output logic [1:0]       m_axis_tuser_o    // [0] c_valid, [1] irq_fire
);
  import kbd_pkg::*;

  localparam int unsigned MapW = $clog2(KEY_MAP_DEPTH);

  state_e            state_q, state_d;
  logic [MapW-1:0]   sweep_q;
  logic              in_fire;
  logic              out_free;

  logic [CMD_W-1:0]  cmd_q;
  logic [WORD_W-1:0] b_q;
  logic [KEY_W-1:0]  kw_q;
  logic              qok_q;
  logic [WORD_W-1:0] msg_q;

  logic [WORD_W-1:0] fold_k;
  logic              held_mem [KEY_MAP_DEPTH];
  logic              held_rd_q;
  logic              held_we;
  logic [MapW-1:0]   held_wa;
  logic              held_wd;

  fifo_ctrl_t        fifo_ctrl;
  fifo_stat_t        fifo_stat;
  logic [KEY_W-1:0]  fifo_rd;

  logic              out_valid_q;
  logic              c_valid_q, c_valid_d;
  logic [WORD_W-1:0] c_value_q, c_value_d;
  logic              fire_q, fire_d;
  logic [WORD_W-1:0] irq_msg_q, irq_msg_d;
  logic              exec;
  logic              key_event;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign exec            = (state_q == S_EXEC);
  assign fold_k          = fold_query(s_axis_tdata_i[15:0]);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sweep_q == MapW'(KEY_MAP_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      sweep_q <= '0;
      msg_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        sweep_q <= sweep_q + 1'b1;
      end
      if (exec && cmd_q == CMD_SET_MSG) begin
        msg_q <= b_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= s_axis_tuser_i;
      b_q   <= s_axis_tdata_i[15:0];
      kw_q  <= s_axis_tdata_i[23:16];
      qok_q <= (fold_k != '0) && (fold_k[WORD_W-1:MapW] == '0);
    end
  end

  assign key_event = exec && (cmd_q == CMD_PRESS || cmd_q == CMD_RELEASE);

  always_comb begin
    held_we = 1'b0;
    held_wa = kw_q;
    held_wd = 1'b0;
    if (state_q == S_CLEAR) begin
      held_we = 1'b1;
      held_wa = sweep_q;
    end else if (key_event) begin
      held_we = 1'b1;
      held_wd = (cmd_q == CMD_PRESS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (held_we) begin
      held_mem[held_wa] <= held_wd;
    end
    held_rd_q <= held_mem[fold_k[MapW-1:0]];
  end

  assign fifo_ctrl.clear = exec && (cmd_q == CMD_CLEAR);
  assign fifo_ctrl.pop   = exec && (cmd_q == CMD_READ);
  assign fifo_ctrl.push  = exec && (cmd_q == CMD_PRESS);

  kbd_key_fifo #(
    .FifoDepth(FifoDepth)
  ) u_key_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (fifo_ctrl),
    .wr_data_i(kw_q),
    .rd_data_o(fifo_rd),
    .stat_o   (fifo_stat)
  );

  always_comb begin
    c_valid_d = 1'b0;
    c_value_d = '0;
    fire_d    = 1'b0;
    irq_msg_d = '0;
    case (cmd_q)
      CMD_READ: begin
        c_valid_d = 1'b1;
        if (!fifo_stat.empty) begin
          c_value_d = WORD_W'(fifo_rd);
        end
      end
      CMD_QUERY: begin
        c_valid_d = 1'b1;
        c_value_d = WORD_W'(qok_q && held_rd_q);
      end
      CMD_PRESS, CMD_RELEASE: begin
        if (msg_q != '0) begin
          fire_d    = 1'b1;
          irq_msg_d = msg_q;
        end
      end
      default: begin
        c_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      c_valid_q <= c_valid_d;
      c_value_q <= c_value_d;
      fire_q    <= fire_d;
      irq_msg_q <= irq_msg_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {irq_msg_q, c_value_q};
  assign m_axis_tuser_o  = {fire_q, c_valid_q};

endmodule

`default_nettype wire

[tb/sv/keyboard_buffer_device_tb.sv]
// Self-checking stream testbench for the keyboard buffer device with a shadow model.
`timescale 1ns / 1ps

module keyboard_buffer_device_tb;
  import kbd_pkg::*;

  localparam int unsigned KEY_FIFO_DEPTH = FIFO_DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS   = 900;

  typedef struct packed {
    logic              c_valid;
    logic [WORD_W-1:0] c_value;
    logic              irq_fire;
    logic [WORD_W-1:0] irq_message;
  } kbd_result_t;

  // Shadow copy of the key FIFO, the held-key map and the interrupt message.
  class keyboard_shadow;
    logic [KEY_W-1:0]  fifo_mem[KEY_FIFO_DEPTH];
    int unsigned       head;
    int unsigned       count;
    logic [WORD_W-1:0] irq_msg;
    bit                held[KEY_MAP_DEPTH];
    kbd_result_t       results_due[$];
    int unsigned       mismatches;

    function new();
      head       = 0;
      count      = 0;
      irq_msg    = '0;
      mismatches = 0;
      foreach (held[i]) held[i] = 1'b0;
    endfunction

    function void apply_item(cmd_e cmd, logic [WORD_W-1:0] b, logic [KEY_W-1:0] kw);
      kbd_result_t       r;
      logic [WORD_W-1:0] key;
      r = '0;
      case (cmd)
        CMD_CLEAR: begin
          head  = 0;
          count = 0;
        end
        CMD_READ: begin
          r.c_valid = 1'b1;
          if (count > 0) begin
            r.c_value = {8'h00, fifo_mem[head]};
            head      = (head + 1) % KEY_FIFO_DEPTH;
            count--;
          end
        end
        CMD_QUERY: begin
          key = b;
          if (b >= UPPER_A && b <= UPPER_Z) begin
            key = b + CASE_DELTA;
          end else if (b == ASCII_LF) begin
            key = KEY_RETURN;
          end
          r.c_valid = 1'b1;
          if (key != 0 && key < KEY_MAP_DEPTH && held[key[KEY_W-1:0]]) begin
            r.c_value = 16'd1;
          end
        end
        CMD_SET_MSG: irq_msg = b;
        CMD_PRESS, CMD_RELEASE: begin
          if (cmd == CMD_PRESS) begin
            if (count < KEY_FIFO_DEPTH) begin
              fifo_mem[(head + count) % KEY_FIFO_DEPTH] = kw;
              count++;
            end
            held[kw] = 1'b1;
          end else begin
            held[kw] = 1'b0;
          end
          if (irq_msg != 0) begin
            r.irq_fire    = 1'b1;
            r.irq_message = irq_msg;
          end
        end
        default: ;
      endcase
      results_due = {results_due, r};
    endfunction

    function void check_result(logic [31:0] data, logic [1:0] flags);
      kbd_result_t want;
      if (results_due.size() == 0) begin
        $error("result beat with nothing expected: data %h flags %b", data, flags);
        mismatches++;
        return;
      end
      want = results_due.pop_front();
      if (flags[0] !== want.c_valid) begin
        $error("c_valid: expected %0d, got %0d", want.c_valid, flags[0]);
        mismatches++;
      end
      if (data[15:0] !== want.c_value) begin
        $error("c_value: expected %h, got %h", want.c_value, data[15:0]);
        mismatches++;
      end
      if (flags[1] !== want.irq_fire) begin
        $error("irq_fire: expected %0d, got %0d", want.irq_fire, flags[1]);
        mismatches++;
      end
      if (data[31:16] !== want.irq_message) begin
        $error("irq_message: expected %h, got %h", want.irq_message, data[31:16]);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;   // [15:0] register_b, [23:16] key_word
  logic [2:0]  s_axis_tuser_i;   // [2:0] command
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // [15:0] c_value, [31:16] irq_message
  logic [1:0]  m_axis_tuser_o;   // [0] c_valid, [1] irq_fire

  keyboard_shadow shadow = new();
  bit             src_steady;
  bit             sink_steady;

  keyboard_buffer_device #(
    .FifoDepth(KEY_FIFO_DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_item(input cmd_e cmd, input logic [15:0] b, input logic [7:0] kw);
    int unsigned gap;
    gap = src_steady ? 0 : $urandom_range(0, 15);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {kw, b};
    do @(posedge clk_i); while (!s_axis_tready_o);
    shadow.apply_item(cmd, b, kw);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (shadow.results_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return 8'h61 + 8'($urandom_range(0, 25));
    if (r == 5) return 8'h10 + 8'($urandom_range(0, 3));
    if (r == 6) return 8'h80 + 8'($urandom_range(0, 3));
    if (r == 7) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_query();
    int unsigned       r;
    logic [7:0]        k;
    r = $urandom_range(0, 9);
    k = pick_key();
    if (r < 3) return {8'h00, k};
    if (r < 5) return 16'h0041 + 16'($urandom_range(0, 25));
    if (r == 5) return ASCII_LF;
    if (r == 6) return 16'h0000;
    if (r == 7) return {8'($urandom_range(1, 255)), k};
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic random_item(input int unsigned press_weight);
    int unsigned r;
    logic [15:0] b;
    logic [7:0]  kw;
    cmd_e        cmd;
    r  = $urandom_range(0, 99);
    b  = 16'($urandom_range(0, 16'hFFFF));
    kw = 8'($urandom_range(0, 255));
    if (r < press_weight) begin
      cmd = CMD_PRESS;
      kw  = pick_key();
    end else if (r < press_weight + 15) begin
      cmd = CMD_RELEASE;
      kw  = pick_key();
    end else if (r < 75) begin
      cmd = CMD_READ;
    end else if (r < 88) begin
      cmd = CMD_QUERY;
      b   = pick_query();
    end else if (r < 95) begin
      cmd = CMD_SET_MSG;
      if ($urandom_range(0, 3) == 0) b = 16'h0000;
    end else begin
      cmd = CMD_CLEAR;
    end
    send_item(cmd, b, kw);
  endtask

  initial begin
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      int unsigned gap;
      if ($urandom_range(0, 63) == 0) sink_steady = ($urandom_range(0, 3) == 0);
      gap = sink_steady ? 0 : $urandom_range(0, 15);
      @(negedge clk_i);
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      shadow.check_result(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  initial begin
    int unsigned press_weight;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = CMD_CLEAR;
    src_steady      = 1'b0;
    sink_steady     = 1'b0;
    press_weight    = 35;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty read, key word zero, query folding and range, FIFO overflow.
    send_item(CMD_READ,    16'h0000, 8'h00);
    send_item(CMD_PRESS,   16'h1234, 8'h00);
    send_item(CMD_QUERY,   16'h0000, 8'h00);
    send_item(CMD_SET_MSG, 16'hFFFF, 8'h00);
    send_item(CMD_PRESS,   16'h0000, 8'hFF);
    send_item(CMD_QUERY,   16'h00FF, 8'h00);
    send_item(CMD_QUERY,   16'hFFFF, 8'hFF);
    send_item(CMD_PRESS,   16'h0000, 8'h61);
    send_item(CMD_QUERY,   16'h0041, 8'h00);
    send_item(CMD_RELEASE, 16'h0000, 8'h61);
    send_item(CMD_QUERY,   16'h0061, 8'h00);
    send_item(CMD_PRESS,   16'h0000, 8'h11);
    send_item(CMD_QUERY,   ASCII_LF, 8'h00);
    send_item(CMD_SET_MSG, 16'h0000, 8'h00);
    send_item(CMD_CLEAR,   16'h0000, 8'h00);
    for (int i = 0; i <= KEY_FIFO_DEPTH; i++) begin
      send_item(CMD_PRESS, 16'h0000, 8'h70 + 8'(i));
    end
    send_item(CMD_QUERY,   16'h0080, 8'h00);
    send_item(CMD_READ,    16'h0000, 8'h00);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) src_steady = ($urandom_range(0, 3) == 0);
      if (n % 100 == 0) press_weight = $urandom_range(15, 45);
      if (n % 150 == 75) drain_results();
      random_item(press_weight);
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (shadow.results_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (shadow.mismatches == 0) begin
      $display("keyboard_buffer_device_tb OK");
    end else begin
      $display("keyboard_buffer_device_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("keyboard_buffer_device_tb NOT OK");
    $finish;
  end

endmodule
